// File: sv/salwc_pkg.sv
// ----------------------------------------------------------------------------
// salwc_pkg
// Shared types and constants for the set-associative LRU write-back cache.
// ----------------------------------------------------------------------------
package salwc_pkg;

  localparam int ADDR_W         = 32;  // width of the byte address field
  localparam int TAG_W          = 30;  // address bits above the smallest block
  localparam int MIN_BLOCK_BITS = 2;
  localparam int BOB_W          = 3;   // block_offset_bits register
  localparam int SIB_W          = 4;   // set_index_bits register
  localparam int SHIFT_W        = 5;   // block + set bits, at most 7 + 15

  localparam logic CFG_BLOCK_OFFSET_BITS = 1'b0;
  localparam logic CFG_SET_INDEX_BITS    = 1'b1;

  localparam logic OP_WRITE = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } salwc_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] wb_addr;
    logic              writeback;
    logic              hit;
  } salwc_result_t;

  // Mask that keeps the low addr_bits of an address beat.
  function automatic logic [ADDR_W-1:0] addr_mask(input int addr_bits);
    logic [ADDR_W-1:0] m;
    if (addr_bits >= ADDR_W) begin
      m = '1;
    end else begin
      m = ADDR_W'((64'd1 << addr_bits) - 64'd1);
    end
    return m;
  endfunction

endpackage

// File: sv/salwc_ram.sv
// ----------------------------------------------------------------------------
// salwc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module salwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/salwc_set_update.sv
// ----------------------------------------------------------------------------
// salwc_set_update
// Tag match, victim choice, LRU age update and new row for one set.
// ----------------------------------------------------------------------------
module salwc_set_update #(
  parameter int WAYS         = 4,
  parameter int SET_W        = 8,
  parameter int ADDRESS_BITS = 32,
  parameter int AGE_W        = (WAYS > 1) ? $clog2(WAYS) : 1,
  parameter int ROW_W        = WAYS * (salwc_pkg::TAG_W + 2 + AGE_W)
) (
  input  logic [ROW_W-1:0]                   row_in,
  input  logic                               op,
  input  logic [salwc_pkg::TAG_W-1:0]        tag,
  input  logic [SET_W-1:0]                   set_idx,
  input  logic [salwc_pkg::BOB_W-1:0]        bob,
  input  logic [salwc_pkg::SHIFT_W-1:0]      shift,
  output logic [ROW_W-1:0]                   row_out,
  output salwc_pkg::salwc_result_t           result
);
  import salwc_pkg::*;

  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W = TAG_W + 2 + AGE_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK = addr_mask(ADDRESS_BITS);

  // Entry layout, low bits up: age, dirty, valid, tag.
  logic [TAG_W-1:0] tag_a   [WAYS];
  logic             valid_a [WAYS];
  logic             dirty_a [WAYS];
  logic [AGE_W-1:0] age_a   [WAYS];

  logic             hit_any;
  logic [WAY_W-1:0] hit_way;
  logic             inv_any;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] lru_way;
  logic [WAY_W-1:0] sel_way;
  logic             wb;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      age_a[w]   = row_in[w*ENT_W +: AGE_W];
      dirty_a[w] = row_in[w*ENT_W + AGE_W];
      valid_a[w] = row_in[w*ENT_W + AGE_W + 1];
      tag_a[w]   = row_in[w*ENT_W + AGE_W + 2 +: TAG_W];
    end
  end

  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    lru_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && valid_a[w] && (tag_a[w] == tag)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!inv_any && !valid_a[w]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(w);
      end
      if (age_a[w] == AGE_W'(WAYS - 1)) begin
        lru_way = WAY_W'(w);
      end
    end
    sel_way = hit_any ? hit_way : (inv_any ? inv_way : lru_way);
    wb      = !hit_any && !inv_any && dirty_a[lru_way];
  end

  always_comb begin
    result.hit       = hit_any;
    result.writeback = wb;
    result.wb_addr   = '0;
    if (wb) begin
      result.wb_addr = ((ADDR_W'(tag_a[lru_way]) << shift) |
                        (ADDR_W'(set_idx) << bob)) & ADDR_MASK;
    end
  end

  // Touch the chosen way: younger ways age by one, chosen way becomes 0.
  always_comb begin
    row_out = row_in;
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == sel_way) begin
        row_out[w*ENT_W +: AGE_W] = '0;
        if (hit_any) begin
          row_out[w*ENT_W + AGE_W] = dirty_a[w] | (op == OP_WRITE);
        end else begin
          row_out[w*ENT_W + AGE_W]              = (op == OP_WRITE);
          row_out[w*ENT_W + AGE_W + 1]          = 1'b1;
          row_out[w*ENT_W + AGE_W + 2 +: TAG_W] = tag;
        end
      end else if (age_a[w] < age_a[sel_way]) begin
        row_out[w*ENT_W +: AGE_W] = age_a[w] + AGE_W'(1);
      end
    end
  end

endmodule

// File: sv/set_assoc_lru_writeback_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache
// Tag and state engine of a set-associative write-back, write-allocate cache.
// ----------------------------------------------------------------------------
// Input beats carry one access each: in_tuser is the op (0 read, 1 write) and
// in_tdata the byte address. Every access yields exactly one output beat:
// out_tuser = {writeback, hit}, out_tdata = the evicted dirty block address
// (zero unless writeback is set).
// Per set, tags, valid, dirty and LRU ages live in one row of a synchronous
// RAM. An access reads its row on the accept edge; the next cycle matches and
// picks the victim, and as the lookup stage advances it writes the updated row
// back while the result loads into the output register. One access per cycle
// is sustained while out_tready is high, also for back-to-back accesses to the
// same set, which take the just-written row from a bypass register.
// cfg_* writes the two split registers; write them only while idle.
// After reset a clearing pass writes every row, one set per cycle, and
// in_tready stays low until the pass ends. When out_tready is low the output
// register holds its beat, one more access waits in the lookup stage, and
// in_tready drops until the output drains.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache #(
  parameter int NUM_SETS     = 256,
  parameter int WAYS         = 4,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input access channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [salwc_pkg::ADDR_W-1:0]        in_tdata,   // [31:0] address
  input  logic                                in_tuser,   // [0] op
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [salwc_pkg::ADDR_W-1:0]        out_tdata,  // [31:0] writeback_address
  output logic [1:0]                          out_tuser,  // [0] hit, [1] writeback
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [salwc_pkg::SIB_W-1:0]         cfg_wdata
);
  import salwc_pkg::*;

  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int MAX_SETB = $clog2(NUM_SETS + 1) - 1;  // floor(log2(NUM_SETS))
  localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W    = TAG_W + 2 + AGE_W;
  localparam int ROW_W    = WAYS * ENT_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK = addr_mask(ADDRESS_BITS);

  function automatic logic [ROW_W-1:0] reset_row();
    logic [ROW_W-1:0] r;
    r = '0;
    for (int w = 0; w < WAYS; w++) begin
      r[w*ENT_W +: AGE_W] = AGE_W'(w);
    end
    return r;
  endfunction

  localparam logic [ROW_W-1:0] RESET_ROW = reset_row();

  // configuration
  logic [BOB_W-1:0] bob_r, bob_nxt;
  logic [SIB_W-1:0] sib_r, sib_nxt;

  // clearing sequencer
  salwc_state_t     st_r, st_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             clearing;

  // address split at accept
  logic [ADDR_W-1:0]  addr_m;
  logic [BOB_W-1:0]   bob_eff;
  logic [SIB_W-1:0]   sib_eff;
  logic [SET_W-1:0]   set_mask;
  logic [SET_W-1:0]   in_set;
  logic [SHIFT_W-1:0] in_shift;
  logic [TAG_W-1:0]   in_tag;
  logic               in_acc;

  // lookup stage
  logic               s1_v_r;
  logic               s1_op_r;
  logic [SET_W-1:0]   s1_set_r;
  logic [TAG_W-1:0]   s1_tag_r;
  logic [BOB_W-1:0]   s1_bob_r;
  logic [SHIFT_W-1:0] s1_shift_r;
  logic               s1_adv;

  // RAM and bypass
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [SET_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;
  logic             fwd_r;
  logic [ROW_W-1:0] fwd_row_r;
  logic [ROW_W-1:0] row_cur;
  logic [ROW_W-1:0] row_new;

  // output register
  salwc_result_t    res;
  salwc_result_t    out_res_r;
  logic             out_v_r;

  always_comb begin
    bob_nxt = bob_r;
    sib_nxt = sib_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BLOCK_OFFSET_BITS: bob_nxt = cfg_wdata[BOB_W-1:0];
        CFG_SET_INDEX_BITS:    sib_nxt = cfg_wdata;
        default:               bob_nxt = bob_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bob_r <= BOB_W'(5);
      sib_r <= SIB_W'(8);
    end else begin
      bob_r <= bob_nxt;
      sib_r <= sib_nxt;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_cnt_r == SET_W'(NUM_SETS - 1)) st_nxt = ST_RUN;
      ST_RUN:   st_nxt = ST_RUN;
      default:  st_nxt = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    clearing    = 1'b0;
    clr_cnt_nxt = clr_cnt_r;
    unique case (st_r)
      ST_CLEAR: begin
        clearing    = 1'b1;
        clr_cnt_nxt = clr_cnt_r + SET_W'(1);
      end
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      st_r      <= st_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    addr_m   = in_tdata & ADDR_MASK;
    bob_eff  = (bob_r < BOB_W'(MIN_BLOCK_BITS)) ? BOB_W'(MIN_BLOCK_BITS) : bob_r;
    sib_eff  = (sib_r > SIB_W'(MAX_SETB)) ? SIB_W'(MAX_SETB) : sib_r;
    // at the full index width the shift wraps to zero and the mask is all ones
    set_mask = (SET_W'(1) << sib_eff) - SET_W'(1);
    in_set   = SET_W'(addr_m >> bob_eff) & set_mask;
    in_shift = SHIFT_W'(bob_eff) + SHIFT_W'(sib_eff);
    in_tag   = TAG_W'(addr_m >> in_shift);
  end

  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !clearing && (!s1_v_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_tuser;
      s1_set_r   <= in_set;
      s1_tag_r   <= in_tag;
      s1_bob_r   <= bob_eff;
      s1_shift_r <= in_shift;
    end
  end

  // a stalled access keeps rereading its own row
  assign ram_raddr = in_acc ? in_set : s1_set_r;
  assign ram_we    = clearing || s1_adv;
  assign ram_waddr = clearing ? clr_cnt_r : s1_set_r;
  assign ram_wdata = clearing ? RESET_ROW : row_new;

  salwc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read and write of one row on the same edge: the read returns stale data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= ram_we && (ram_raddr == ram_waddr);
    end
  end

  always_ff @(posedge clk) begin
    fwd_row_r <= ram_wdata;
  end

  assign row_cur = fwd_r ? fwd_row_r : ram_rdata;

  salwc_set_update #(
    .WAYS         (WAYS),
    .SET_W        (SET_W),
    .ADDRESS_BITS (ADDRESS_BITS),
    .AGE_W        (AGE_W),
    .ROW_W        (ROW_W)
  ) u_set_update (
    .row_in  (row_cur),
    .op      (s1_op_r),
    .tag     (s1_tag_r),
    .set_idx (s1_set_r),
    .bob     (s1_bob_r),
    .shift   (s1_shift_r),
    .row_out (row_new),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_res_r.wb_addr;
  assign out_tuser  = {out_res_r.writeback, out_res_r.hit};

endmodule
